// ----- rtl/ucfr_pkg.sv -----
`default_nettype none

package ucfr_pkg;

	// Receive buffer size in bytes; a frame of header, payload and CRC must fit.
	localparam int BUFFER_BYTES = 64;
	// Frame byte counter width: the last byte of a fitting frame has index BUFFER_BYTES - 1.
	localparam int CNT_W = $clog2(BUFFER_BYTES);

	localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND = 8'h55;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_TOP     = 16'h8000;

	localparam int HEADER_BYTES  = 5;
	localparam int TRAILER_BYTES = 2;
	localparam int KEPT_BYTES    = 12;
	localparam int NUM_WORDS     = KEPT_BYTES / 4;

	// Byte positions inside the frame header.
	localparam logic [CNT_W-1:0] POS_SYNC1   = CNT_W'(0);
	localparam logic [CNT_W-1:0] POS_SYNC2   = CNT_W'(1);
	localparam logic [CNT_W-1:0] POS_COMMAND = CNT_W'(2);
	localparam logic [CNT_W-1:0] POS_LEN_HI  = CNT_W'(3);
	localparam logic [CNT_W-1:0] POS_LEN_LO  = CNT_W'(4);

	// Packed result width and its byte-padded bus width.
	localparam int RES_W  = 2 + 8 + 16 + 32 * NUM_WORDS;
	localparam int DATA_W = ((RES_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_SYNC = 2'd1,
		STATUS_BAD_CRC  = 2'd2,
		STATUS_TOO_LONG = 2'd3
	} status_t;

	// One frame report; the last field (status) sits in the lowest bits when packed.
	typedef struct packed {
		logic [31:0] word_c;
		logic [31:0] word_b;
		logic [31:0] word_a;
		logic [15:0] payload_len;
		logic [7:0]  command;
		status_t     status;
	} result_t;

	// CRC-16/CCITT-FALSE update with one byte, MSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ucfr_in_stage.sv -----
`default_nettype none

module ucfr_in_stage
	import ucfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // rx_byte [7:0]
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	logic valid_q;

	// The register takes a new byte whenever it is empty or its byte moves on.
	assign s_tready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	// Payload register, no reset needed.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ucfr_parser.sv -----
`default_nettype none

module ucfr_parser
	import ucfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] rx_byte,
	output logic            res_valid,
	output result_t         res
);

	logic [CNT_W-1:0]           count_q, count_d;
	logic [15:0]                length_q, length_d;
	logic [15:0]                crc_q, crc_d;
	logic [7:0]                 command_q, command_d;
	logic                       sync_good_q, sync_good_d;
	logic [7:0]                 crc_hi_q, crc_hi_d;
	logic [NUM_WORDS-1:0][31:0] words_q, words_d;

	logic [15:0] crc_upd;
	logic [15:0] len_full;
	logic [16:0] frame_len;
	logic        too_long;
	logic [CNT_W-1:0] pos;
	logic [15:0] pos16;

	assign crc_upd   = crc_byte(crc_q, rx_byte);
	assign len_full  = {length_q[15:8], rx_byte};
	assign frame_len = {1'b0, len_full} + 17'(HEADER_BYTES + TRAILER_BYTES);
	assign too_long  = frame_len > 17'(BUFFER_BYTES);
	assign pos       = count_q - CNT_W'(HEADER_BYTES);
	assign pos16     = {{(16 - CNT_W){1'b0}}, pos};

	// Next state and the report for one byte.
	always_comb begin
		count_d     = count_q;
		length_d    = length_q;
		crc_d       = crc_q;
		command_d   = command_q;
		sync_good_d = sync_good_q;
		crc_hi_d    = crc_hi_q;
		words_d     = words_q;
		res_valid   = 1'b0;
		res.status      = STATUS_OK;
		res.command     = command_q;
		res.payload_len = length_q;
		res.word_a      = words_q[0];
		res.word_b      = words_q[1];
		res.word_c      = words_q[2];

		unique case (count_q)
			POS_SYNC1: begin
				// Hunt for the first sync byte.
				if (rx_byte == SYNC_FIRST) begin
					crc_d   = crc_byte(CRC_INIT, rx_byte);
					words_d = '0;
					count_d = POS_SYNC2;
				end
			end
			POS_SYNC2: begin
				sync_good_d = (rx_byte == SYNC_SECOND);
				crc_d       = crc_upd;
				count_d     = POS_COMMAND;
			end
			POS_COMMAND: begin
				command_d = rx_byte;
				crc_d     = crc_upd;
				count_d   = POS_LEN_HI;
			end
			POS_LEN_HI: begin
				length_d = {rx_byte, 8'h00};
				crc_d    = crc_upd;
				count_d  = POS_LEN_LO;
			end
			POS_LEN_LO: begin
				// A frame that cannot fit is reported at once and dropped.
				length_d = len_full;
				crc_d    = crc_upd;
				if (too_long) begin
					count_d         = POS_SYNC1;
					res_valid       = 1'b1;
					res.status      = STATUS_TOO_LONG;
					res.payload_len = len_full;
					res.word_a      = '0;
					res.word_b      = '0;
					res.word_c      = '0;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			default: begin
				if (pos16 < length_q) begin
					// Payload byte: keep the first twelve, big-endian.
					for (int k = 0; k < KEPT_BYTES; k++) begin
						if (pos16 == 16'(k)) begin
							words_d[k / 4][8 * (3 - (k % 4)) +: 8] =
								words_q[k / 4][8 * (3 - (k % 4)) +: 8] | rx_byte;
						end
					end
					crc_d   = crc_upd;
					count_d = count_q + CNT_W'(1);
				end else if (pos16 == length_q) begin
					crc_hi_d = rx_byte;
					count_d  = count_q + CNT_W'(1);
				end else begin
					// Last CRC byte closes the frame.
					count_d   = POS_SYNC1;
					res_valid = 1'b1;
					if (!sync_good_q) begin
						res.status = STATUS_BAD_SYNC;
					end else if ({crc_hi_q, rx_byte} != crc_q) begin
						res.status = STATUS_BAD_CRC;
					end else begin
						res.status = STATUS_OK;
					end
				end
			end
		endcase
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= POS_SYNC1;
			length_q    <= '0;
			crc_q       <= CRC_INIT;
			command_q   <= '0;
			sync_good_q <= 1'b0;
			crc_hi_q    <= '0;
			words_q     <= '0;
		end else if (fire) begin
			count_q     <= count_d;
			length_q    <= length_d;
			crc_q       <= crc_d;
			command_q   <= command_d;
			sync_good_q <= sync_good_d;
			crc_hi_q    <= crc_hi_d;
			words_q     <= words_d;
		end
	end

	// A report always sends the counter back to hunting.
	a_report_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid |=> count_q == POS_SYNC1)
		else $error("frame report did not restart the sync hunt");

	// A found sync byte clears the kept payload words.
	a_sync_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && count_q == POS_SYNC1 && rx_byte == SYNC_FIRST |=> words_q == '0)
		else $error("payload words not cleared at frame start");

	// Past the header, the accepted frame always fits the buffer.
	a_fits: assert property (@(posedge clk) disable iff (!arst_n)
		count_q > POS_LEN_LO |->
		({1'b0, length_q} + 17'(HEADER_BYTES + TRAILER_BYTES)) <= 17'(BUFFER_BYTES))
		else $error("payload collected for a frame that does not fit");

endmodule

`default_nettype wire

// ----- rtl/ucfr_out_stage.sv -----
`default_nettype none

module ucfr_out_stage
	import ucfr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire result_t  res,
	output logic          advance,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	output logic [DATA_W-1:0] m_tdata
);

	logic    valid_q;
	result_t res_q;

	// The stage moves when the result register is empty or being drained.
	assign advance  = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {{(DATA_W - RES_W){1'b0}}, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/uart_command_frame_receiver_top.sv -----
`default_nettype none

// Frame receiver for a byte stream: sync 0xAA 0x55, command, 16-bit big-endian
// length, payload and a CRC-16/CCITT-FALSE over everything before the CRC.
// Input channel s_*: one received byte per transaction in s_tdata[7:0].
// Output channel m_*: one report per finished or dropped frame. A frame whose
// header, payload and CRC exceed BUFFER_BYTES is reported as too long right
// after its length bytes, with zero words, and hunting restarts.
// A report reaches m_tvalid through the input register and then the result
// register after the last byte of its frame is accepted.
// Throughput: one byte per cycle while the result side can move; the byte-wide
// CRC update sits in the single logic stage between the two registers.
// Reset clears both valid flags and the frame state; the block then hunts for
// the first sync byte with the CRC at 0xFFFF.
// When m_tready is low with a report waiting, the input register still holds
// one further byte; after that s_tready drops until the report is taken.
module uart_command_frame_receiver_top
	import ucfr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,   // rx_byte [7:0]
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [DATA_W-1:0]      m_tdata    // status [1:0], command [9:2],
	                                          // payload_len [25:10], word_a [57:26],
	                                          // word_b [89:58], word_c [121:90]
);

	logic       advance;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fire;
	logic       res_valid;
	result_t    res;

	// A byte in the input register is processed once the result side can move.
	assign fire = valid_s1 && advance;

	ucfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	ucfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ucfr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire && res_valid),
		.res      (res),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire
